/* src/frh_pkg.sv */
package frh_pkg;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [8:0] DIM_RESET = 9'd256;
  localparam logic [2:0] DIV_LAST  = 3'd7;
  localparam logic [7:0] ALPHA_MAX = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_FETCH,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  col;
    logic [7:0]  row_index;
    logic [31:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        blank;
  } out_word_t;

  typedef struct packed {
    logic store;
    logic load;
    logic prep;
    logic fetch;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic blank;
    logic fade;
  } dp_status_t;

endpackage

/* src/frh_ctrl.sv */
module frh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               is_read_i,
  input  frh_pkg::dp_status_t status_i,
  output frh_pkg::dp_cmd_t   cmd_o,
  output logic               busy_o,
  output logic               emit_o
);

  frh_pkg::state_e state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frh_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      frh_pkg::S_IDLE: begin
        if (start) begin
          if (is_read_i) begin
            cmd_o.load = 1'b1;
            state_d    = frh_pkg::S_PREP;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      frh_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = frh_pkg::S_FETCH;
      end
      frh_pkg::S_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (status_i.blank || !status_i.fade) begin
          state_d = frh_pkg::S_OUT;
        end else begin
          cnt_d   = '0;
          state_d = frh_pkg::S_DIV;
        end
      end
      frh_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == frh_pkg::DIV_LAST) begin
          state_d = frh_pkg::S_OUT;
        end
      end
      frh_pkg::S_OUT: begin
        state_d = frh_pkg::S_IDLE;
      end
      default: begin
        state_d = frh_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != frh_pkg::S_IDLE);
  assign emit_o = (state_q == frh_pkg::S_OUT);

endmodule

/* src/frh_dp.sv */
module frh_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk_i,
  input  frh_pkg::dp_cmd_t    cmd_i,
  input  frh_pkg::in_word_t   in_word_i,
  input  logic [8:0]          frame_width_i,
  input  logic [8:0]          frame_height_i,
  output frh_pkg::dp_status_t status_o,
  output frh_pkg::out_word_t  result_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] RowPitch = AddrW'(MAX_WIDTH);

  logic [31:0] mem [Depth];

  logic [7:0]  col_q, row_q;
  logic        blank_q, fade_q, high_q, src_ok_q;
  logic [8:0]  src_q;
  logic [8:0]  rem_q;
  logic [7:0]  quo_q;
  logic [31:0] pix_q;

  logic [7:0]       half, quarter, mirror, fade_arg;
  logic             in_lo, in_hi, blank, src_ok, wr_ok;
  logic [8:0]       src, span;
  logic [16:0]      num;
  logic [9:0]       trial;
  logic             ge;
  logic [8:0]       rem_next;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       alpha;

  always_comb begin
    half     = frame_height_i[8:1];
    quarter  = {1'b0, half[7:1]};
    in_lo    = row_q < quarter;
    in_hi    = row_q >= (half - quarter);
    mirror   = half - 8'd1 - row_q;
    src      = (in_lo || in_hi) ? {mirror, 1'b0} : {row_q, 1'b0};
    fade_arg = in_lo ? row_q : mirror;
    span     = frame_height_i - {1'b0, fade_arg};
    num      = {span, 8'b0} - {8'b0, span};
    blank    = (row_q >= half) || ({1'b0, col_q} >= frame_width_i);
    src_ok   = (32'(src) < 32'(MAX_HEIGHT)) && (32'(col_q) < 32'(MAX_WIDTH));

    wr_ok    = (32'(in_word_i.row_index) < 32'(MAX_HEIGHT)) &&
               (32'(in_word_i.col) < 32'(MAX_WIDTH));
    wr_addr  = AddrW'(in_word_i.row_index) * RowPitch + AddrW'(in_word_i.col);
    rd_addr  = AddrW'(src_q) * RowPitch + AddrW'(col_q);

    trial    = {rem_q, quo_q[7]};
    ge       = trial >= {1'b0, frame_height_i};
    rem_next = ge ? 9'(trial - {1'b0, frame_height_i}) : trial[8:0];

    if (fade_q) begin
      alpha = high_q ? (frh_pkg::ALPHA_MAX - quo_q) : quo_q;
    end else begin
      alpha = pix_q[31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= in_word_i.col;
      row_q <= in_word_i.row_index;
    end
    if (cmd_i.prep) begin
      blank_q  <= blank;
      fade_q   <= in_lo || in_hi;
      high_q   <= !in_lo;
      src_q    <= src;
      src_ok_q <= src_ok;
      rem_q    <= num[16:8];
      quo_q    <= num[7:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[6:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && wr_ok) begin
      mem[wr_addr] <= in_word_i.pixel_in;
    end
    if (cmd_i.fetch) begin
      pix_q <= src_ok_q ? mem[rd_addr] : '0;
    end
  end

  assign status_o.blank     = blank_q;
  assign status_o.fade      = fade_q;
  assign result_o.pixel_out = blank_q ? '0 : {alpha, pix_q[23:0]};
  assign result_o.blank     = blank_q;

endmodule

/* src/frame_reflect_half_fade.sv */
// Channel   Direction  Handshake                        Payload
// config    in/out     psel, penable, pwrite, pready    paddr, pwdata, prdata
// command   in         start, busy                      in_word_i
// result    out        result_valid_o                   result_o
//
// A store word is taken while the controller stays idle, and busy stays low.
// A read word passes through PREP and FETCH to OUT, where its result is given, when blank or in the middle row,
// and also through the DIV steps before OUT when the alpha fade applies; busy stays high until OUT ends.
// The fade cycles come from the 8-step restoring divider for floor(255*(H-y)/H).
// Reset sets both frame dimensions to 256 and idles the controller; the frame memory is not cleared.
// Each result is on the ports for one cycle only and must be taken then.
module frame_reflect_half_fade #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  frh_pkg::in_word_t  in_word_i,
  output logic               result_valid_o,
  output frh_pkg::out_word_t result_o
);

  logic [8:0] width_q, width_d, height_q, height_d;
  logic [8:0] rd_reg;

  frh_pkg::dp_cmd_t    cmd;
  frh_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= frh_pkg::DIM_RESET;
      height_q <= frh_pkg::DIM_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        frh_pkg::REG_FRAME_WIDTH:  width_d  = pwdata[8:0];
        frh_pkg::REG_FRAME_HEIGHT: height_d = pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      frh_pkg::REG_FRAME_WIDTH:  rd_reg = width_q;
      frh_pkg::REG_FRAME_HEIGHT: rd_reg = height_q;
      default:                   rd_reg = '0;
    endcase
  end

  assign prdata = {23'b0, rd_reg};
  assign pready = 1'b1;

  frh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .is_read_i (in_word_i.func == frh_pkg::FUNC_READ),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .emit_o    (result_valid_o)
  );

  frh_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .in_word_i      (in_word_i),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .status_o       (status),
    .result_o       (result_o)
  );

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_blank_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.blank) |-> (result_o.pixel_out == 32'd0))
    else $error("blank result carries a nonzero pixel");

  a_store_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.func == frh_pkg::FUNC_STORE) |=> !busy)
    else $error("store word left the block busy");

  a_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.func == frh_pkg::FUNC_READ) |=> (busy && !result_valid_o))
    else $error("read word did not occupy the block");

endmodule
